[rtl/core/four_servo_ramp_controller_defines.svh]
// Assertion macros shared by the servo ramp controller checkers.
// No dependencies; included by the checker file.
`ifndef FOUR_SERVO_RAMP_CONTROLLER_DEFINES_SVH
`define FOUR_SERVO_RAMP_CONTROLLER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FSRC_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FSRC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/fsrc_pkg.sv]
// Types, codes and constants of the four-servo ramp controller.
// No dependencies; used by every RTL file of the block.
package fsrc_pkg;

    localparam int unsigned NumServos   = 4;
    localparam int unsigned PulseWidth  = 12;
    localparam int unsigned SetupWidth  = 34;
    localparam int unsigned CfgIdxWidth = 3;

    // x/5 for x < 4096 is exactly (x * 52429) >> 18
    localparam logic [15:0] DivFiveRecip = 16'd52429;
    localparam int unsigned DivFiveShift = 18;

    localparam logic [PulseWidth-1:0] PulseReset    = 12'd750;
    localparam logic [PulseWidth-1:0] PulseMax      = 12'hFFF;
    localparam logic [7:0]            PositionReset = 8'd150;
    localparam logic [7:0]            SettleReset   = 8'd50;
    localparam logic [7:0]            MinPosReset   = 8'd50;
    localparam logic [7:0]            MaxPosReset   = 8'd250;
    localparam logic [15:0]           ReloadBase    = 16'hFFFF;

    typedef enum logic [1:0] {
        OP_FRAME_TICK = 2'd0,
        OP_PULSE_END  = 2'd1,
        OP_SENSOR_POLL = 2'd2,
        OP_SET_WANTED = 2'd3
    } op_t;

    typedef enum logic [CfgIdxWidth-1:0] {
        REG_SETUP_0      = 3'd0,
        REG_SETUP_1      = 3'd1,
        REG_SETUP_2      = 3'd2,
        REG_SETUP_3      = 3'd3,
        REG_NODE_NUMBER  = 3'd4,
        REG_SETTLE_TICKS = 3'd5,
        REG_MIN_POSITION = 3'd6,
        REG_MAX_POSITION = 3'd7
    } reg_index_t;

    localparam logic [1:0] RELAY_END_NONE = 2'd0;
    localparam logic [1:0] RELAY_END_ONE  = 2'd1;
    localparam logic [1:0] RELAY_END_TWO  = 2'd2;

    localparam logic [1:0] SENSE_NONE     = 2'd0;
    localparam logic [1:0] SENSE_STRAIGHT = 2'd1;
    localparam logic [1:0] SENSE_THROWN   = 2'd2;

    // Per-servo setup word, packed as written on the config port
    typedef struct packed {
        logic [15:0] fb_addr;
        logic        ext_sensors;
        logic        polarity;
        logic [7:0]  right_pos;
        logic [7:0]  speed;
    } servo_setup_t;

    typedef struct packed {
        op_t        operation;
        logic [1:0] target_servo;
        logic [7:0] target_position;
        logic [7:0] sensor_bits;
    } fsrc_in_t;

    typedef struct packed {
        logic [1:0]  active_slot;
        logic        pulse_enable;
        logic [15:0] timer_reload;
        logic        at_target;
        logic        relay_start;
        logic [1:0]  relay_end;
        logic        report_valid;
        logic        report_on;
        logic [15:0] report_address;
        logic [1:0]  turnout_state;
    } fsrc_out_t;

    // Frame-tick outcome for one slot: new slot state and result fields
    typedef struct packed {
        logic [PulseWidth-1:0] pulse_next;
        logic [7:0]            position_next;
        logic [7:0]            settle_next;
        logic                  moved;
        logic                  arrived;
        logic                  up;
        logic                  at_target;
        logic                  pulse_enable;
        logic [1:0]            relay_end;
        logic [15:0]           timer_reload;
    } ramp_res_t;

endpackage

[rtl/core/four_servo_ramp_controller.sv]
// Four-servo ramp controller, top level. Depends on fsrc_pkg and fsrc_ramp.
//
// Drives four RC servos in turn. Every request on the s_ channel gives exactly
// one result on the m_ channel, in order. A frame tick ramps the current slot's
// pulse by its speed toward the wanted position (position = pulse / 5, clamped
// to min/max), reports arrival or runs the sensor check for servos with
// external sensors, and returns the pulse timer reload and the pulse enable
// gated by the settle counter. A pulse end advances the slot, a sensor poll
// checks the next sensor pair, and a set request changes a wanted position.
// Rate: one request per clock while m_ready is held high. A request is
// captured in the input register, and from there the whole slot update (add,
// divide-by-5 multiply, clamp, settle compare) runs in one pass into the
// result register and the slot state. The input register takes a new request
// when it is empty or its request moves on, so both sides can stall freely.
// Configuration is written through cfg_we/cfg_index/cfg_wdata, by the user only
// while idle, which the block does not enforce; the node number register is
// accepted but no result field carries it, so it is not stored.
module four_servo_ramp_controller
    import fsrc_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   cfg_we,
    input  logic [CfgIdxWidth-1:0] cfg_index,
    input  logic [SetupWidth-1:0]  cfg_wdata,

    input  logic                   s_valid,
    output logic                   s_ready,
    input  fsrc_in_t               s_data,

    output logic                   m_valid,
    input  logic                   m_ready,
    output fsrc_out_t              m_data
);

    // configuration
    servo_setup_t          setup_reg [NumServos];
    logic [7:0]            settle_ticks_reg;
    logic [7:0]            min_position_reg;
    logic [7:0]            max_position_reg;

    // per-slot state
    logic [PulseWidth-1:0] pulse_reg    [NumServos];
    logic [7:0]            position_reg [NumServos];
    logic [7:0]            wanted_reg   [NumServos];
    logic [7:0]            settle_reg   [NumServos];
    logic                  last_st_reg  [NumServos];
    logic                  last_th_reg  [NumServos];
    logic [1:0]            cur_slot_reg;
    logic [1:0]            poll_slot_reg;

    // input register and result register
    logic                  in_valid_reg;
    fsrc_in_t              in_data_reg;
    logic                  out_valid_reg;
    fsrc_out_t             out_data_reg;
    fsrc_out_t             out_data_next;

    logic                  advance;
    ramp_res_t             ramp;
    logic [1:0]            sc_slot;
    logic                  sc_st;
    logic                  sc_th;
    logic                  sc_change;
    logic                  sc_enable;

    // The head request moves into the result register when that is empty or
    // being drained this cycle.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    fsrc_ramp u_ramp (
        .setup        (setup_reg[cur_slot_reg]),
        .pulse        (pulse_reg[cur_slot_reg]),
        .position     (position_reg[cur_slot_reg]),
        .wanted       (wanted_reg[cur_slot_reg]),
        .settle       (settle_reg[cur_slot_reg]),
        .settle_ticks (settle_ticks_reg),
        .min_position (min_position_reg),
        .max_position (max_position_reg),
        .res          (ramp)
    );

    // Sensor check: a poll looks at poll_slot, an arrival with external
    // sensors looks at the current slot. Equal bits or an unchanged pair is
    // no news.
    always_comb begin
        sc_slot   = (in_data_reg.operation == OP_SENSOR_POLL) ? poll_slot_reg : cur_slot_reg;
        sc_st     = in_data_reg.sensor_bits[{sc_slot, 1'b0}];
        sc_th     = in_data_reg.sensor_bits[{sc_slot, 1'b1}];
        sc_change = (sc_st != sc_th)
                 && !((sc_st == last_st_reg[sc_slot]) && (sc_th == last_th_reg[sc_slot]));
        sc_enable = (in_data_reg.operation == OP_SENSOR_POLL)
                 || ((in_data_reg.operation == OP_FRAME_TICK) && ramp.arrived
                     && setup_reg[cur_slot_reg].ext_sensors);
    end

    // Result fields; anything that means nothing for the request stays zero.
    always_comb begin
        out_data_next = '0;
        unique case (in_data_reg.operation)
            OP_FRAME_TICK: begin
                out_data_next.active_slot  = cur_slot_reg;
                out_data_next.pulse_enable = ramp.pulse_enable;
                out_data_next.timer_reload = ramp.timer_reload;
                out_data_next.at_target    = ramp.at_target;
                out_data_next.relay_start  = ramp.moved;
                out_data_next.relay_end    = ramp.relay_end;
                if (ramp.arrived && !setup_reg[cur_slot_reg].ext_sensors) begin
                    // arriving upward reports off, downward reports on
                    out_data_next.report_valid   = 1'b1;
                    out_data_next.report_on      = !ramp.up;
                    out_data_next.report_address = setup_reg[cur_slot_reg].fb_addr;
                end
            end
            OP_PULSE_END: begin
                out_data_next.active_slot = cur_slot_reg;
            end
            OP_SENSOR_POLL: begin
                out_data_next.active_slot = poll_slot_reg;
            end
            OP_SET_WANTED: begin
                out_data_next.active_slot = in_data_reg.target_servo;
            end
        endcase
        if (sc_enable && sc_change) begin
            out_data_next.report_valid   = 1'b1;
            out_data_next.report_on      = sc_th;
            out_data_next.report_address = setup_reg[sc_slot].fb_addr;
            out_data_next.turnout_state  = sc_th ? SENSE_THROWN : SENSE_STRAIGHT;
        end
    end

    // Handshake registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NumServos; i++) begin
                setup_reg[i] <= '0;
            end
            settle_ticks_reg <= SettleReset;
            min_position_reg <= MinPosReset;
            max_position_reg <= MaxPosReset;
        end else if (cfg_we) begin
            unique case (cfg_index) inside
                REG_SETUP_0, REG_SETUP_1, REG_SETUP_2, REG_SETUP_3: begin
                    setup_reg[cfg_index[1:0]] <= cfg_wdata;
                end
                REG_NODE_NUMBER: begin
                    // framing lives outside this block; nothing to keep
                end
                REG_SETTLE_TICKS: settle_ticks_reg <= cfg_wdata[7:0];
                REG_MIN_POSITION: min_position_reg <= cfg_wdata[7:0];
                REG_MAX_POSITION: max_position_reg <= cfg_wdata[7:0];
            endcase
        end
    end

    // Slot state update, one request per cycle while the result register can advance
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NumServos; i++) begin
                pulse_reg[i]    <= PulseReset;
                position_reg[i] <= PositionReset;
                wanted_reg[i]   <= PositionReset;
                settle_reg[i]   <= '0;
                last_st_reg[i]  <= 1'b0;
                last_th_reg[i]  <= 1'b0;
            end
            cur_slot_reg  <= '0;
            poll_slot_reg <= '0;
        end else if (advance) begin
            unique case (in_data_reg.operation)
                OP_FRAME_TICK: begin
                    pulse_reg[cur_slot_reg]    <= ramp.pulse_next;
                    position_reg[cur_slot_reg] <= ramp.position_next;
                    settle_reg[cur_slot_reg]   <= ramp.settle_next;
                end
                OP_PULSE_END: begin
                    cur_slot_reg <= cur_slot_reg + 2'd1;
                end
                OP_SENSOR_POLL: begin
                    poll_slot_reg <= poll_slot_reg + 2'd1;
                end
                OP_SET_WANTED: begin
                    wanted_reg[in_data_reg.target_servo] <= in_data_reg.target_position;
                end
            endcase
            if (sc_enable && sc_change) begin
                last_st_reg[sc_slot] <= sc_st;
                last_th_reg[sc_slot] <= sc_th;
            end
        end
    end

endmodule

[rtl/core/fsrc_ramp.sv]
// One frame-tick step of a servo slot: pulse ramp, position, clamp, settle.
// Depends on fsrc_pkg.
module fsrc_ramp
    import fsrc_pkg::*;
(
    input  servo_setup_t          setup,
    input  logic [PulseWidth-1:0] pulse,
    input  logic [7:0]            position,
    input  logic [7:0]            wanted,
    input  logic [7:0]            settle,
    input  logic [7:0]            settle_ticks,
    input  logic [7:0]            min_position,
    input  logic [7:0]            max_position,
    output ramp_res_t             res
);

    logic                  moving;
    logic                  up;
    logic [PulseWidth:0]   up_sum;
    logic [PulseWidth-1:0] up_pulse;
    logic [PulseWidth-1:0] dn_pulse;
    logic [PulseWidth-1:0] stepped;
    logic [27:0]           quot_prod;
    logic [9:0]            quot;
    logic                  arrived;
    logic [9:0]            pos_raw;
    logic [9:0]            pos_min;
    logic [9:0]            pos_clamped;
    logic [7:0]            pos_new;
    logic [PulseWidth-1:0] pulse_new;
    logic [7:0]            settle_base;
    logic [7:0]            settle_new;
    logic                  at_tgt;
    logic [15:0]           pulse_ext;
    logic [15:0]           pulse_x15;

    always_comb begin
        moving = (wanted != position);
        up     = (wanted > position);

        up_sum   = {1'b0, pulse} + {{(PulseWidth - 7){1'b0}}, setup.speed};
        up_pulse = up_sum[PulseWidth] ? PulseMax : up_sum[PulseWidth-1:0];
        dn_pulse = (pulse > {{(PulseWidth - 8){1'b0}}, setup.speed})
                 ? pulse - {{(PulseWidth - 8){1'b0}}, setup.speed}
                 : '0;
        stepped  = up ? up_pulse : dn_pulse;

        // position before clamping is pulse / 5 (reciprocal multiply)
        quot_prod = {16'd0, stepped} * {12'd0, DivFiveRecip};
        quot      = quot_prod[27:DivFiveShift];

        arrived = moving && (up ? (quot >= {2'b00, wanted}) : (quot <= {2'b00, wanted}));

        if (!moving) begin
            pos_raw = {2'b00, position};
        end else if (arrived) begin
            pos_raw = {2'b00, wanted};
        end else begin
            pos_raw = quot;
        end

        // min first, then max, so max wins when the limits cross
        pos_min     = (pos_raw < {2'b00, min_position}) ? {2'b00, min_position} : pos_raw;
        pos_clamped = (pos_min > {2'b00, max_position}) ? {2'b00, max_position} : pos_min;
        pos_new     = pos_clamped[7:0];

        pulse_new   = moving ? stepped : pulse;
        settle_base = moving ? 8'd0 : settle;
        at_tgt      = (pos_new == wanted);
        settle_new  = (at_tgt && (settle_base < settle_ticks)) ? settle_base + 8'd1
                                                               : settle_base;

        pulse_ext = {4'd0, pulse_new};
        pulse_x15 = {pulse_ext[11:0], 4'd0} - pulse_ext;

        res.pulse_next    = pulse_new;
        res.position_next = pos_new;
        res.settle_next   = settle_new;
        res.moved         = moving;
        res.arrived       = arrived;
        res.up            = up;
        res.at_target     = at_tgt;
        res.pulse_enable  = (settle_new < settle_ticks);
        res.timer_reload  = ReloadBase - pulse_x15;
        if (!arrived) begin
            res.relay_end = RELAY_END_NONE;
        end else if (wanted == setup.right_pos) begin
            res.relay_end = setup.polarity ? RELAY_END_TWO : RELAY_END_ONE;
        end else begin
            res.relay_end = setup.polarity ? RELAY_END_ONE : RELAY_END_TWO;
        end
    end

endmodule

[rtl/core/fsrc_checker.sv]
// Port-level assertions for four_servo_ramp_controller, bound to the top level.
// Depends on fsrc_pkg and four_servo_ramp_controller_defines.svh.
`include "four_servo_ramp_controller_defines.svh"

module fsrc_checker
    import fsrc_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input fsrc_in_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input fsrc_out_t m_data
);

    // a stalled result holds
    `FSRC_ASSERT_NEXT(a_result_holds, aclk, aresetn,
        m_valid && !m_ready, m_valid && $stable(m_data), "stalled result changed")

    // no report means no report fields
    `FSRC_ASSERT_NOW(a_report_fields, aclk, aresetn,
        m_valid && !m_data.report_valid,
        !m_data.report_on && (m_data.report_address == 16'd0),
        "report fields set without a report")

    // a relay end code only comes with a move
    `FSRC_ASSERT_NOW(a_relay_end_moved, aclk, aresetn,
        m_valid && (m_data.relay_end != RELAY_END_NONE),
        m_data.relay_start && (m_data.relay_end != 2'd3), "relay end without a move")

    // a known turnout state is always reported
    `FSRC_ASSERT_NOW(a_turnout_report, aclk, aresetn,
        m_valid && (m_data.turnout_state != SENSE_NONE),
        m_data.report_valid && (m_data.turnout_state != 2'd3),
        "turnout state without a report")

endmodule

bind four_servo_ramp_controller fsrc_checker u_fsrc_checker (.*);
